// ===== sv/hmbd_pkg.sv =====
package hmbd_pkg;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LENBODY = 3'd2,
    PH_CSIZE   = 3'd3,
    PH_CDATA   = 3'd4,
    PH_FOOTER  = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NO_COLON = 2'd0;
  localparam logic [1:0] ERR_NO_FRAME = 2'd1;
  localparam logic [1:0] ERR_BAD_SIZE = 2'd2;

  localparam logic [1:0] NUM_IDLE = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE = 2'd2;
  localparam logic [1:0] NUM_BAD = 2'd3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;

  localparam logic [7:0] CL_LEN = 8'd14;
  localparam logic [7:0] TE_LEN = 8'd17;
  localparam logic [7:0] CK_LEN = 8'd7;
  localparam logic [7:0] POS_MAX = 8'd255;

  typedef struct packed {
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
    logic       is_blank;
    logic       is_sptab;
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic [7:0] pos;
    logic       kcl;
    logic       kte;
    logic       kcolon;
    logic       kchk;
    logic       colon_bad;
    logic       vstart;
    logic [7:0] vlen;
    logic [1:0] np;
    logic       neg;
  } line_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] kind;
    logic [7:0] data;
    logic       eom;
    logic [1:0] code;
  } emit_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r.is_dec = 1'b1;
      r.is_hex = 1'b1;
      r.nib = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      r.is_hex = 1'b1;
      r.nib = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      r.is_hex = 1'b1;
      r.nib = 4'(c - "A" + 8'd10);
    end
    r.is_sptab = (c == CH_SPACE) || (c == 8'd9);
    r.is_blank = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [7:0] p);
    case (p)
      8'd0: return "C";   8'd1: return "o";   8'd2: return "n";   8'd3: return "t";
      8'd4: return "e";   8'd5: return "n";   8'd6: return "t";   8'd7: return "-";
      8'd8: return "L";   8'd9: return "e";   8'd10: return "n";  8'd11: return "g";
      8'd12: return "t";  8'd13: return "h";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] te_char(input logic [7:0] p);
    case (p)
      8'd0: return "T";   8'd1: return "r";   8'd2: return "a";   8'd3: return "n";
      8'd4: return "s";   8'd5: return "f";   8'd6: return "e";   8'd7: return "r";
      8'd8: return "-";   8'd9: return "E";   8'd10: return "n";  8'd11: return "c";
      8'd12: return "o";  8'd13: return "d";  8'd14: return "i";  8'd15: return "n";
      8'd16: return "g";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] ck_char(input logic [7:0] p);
    case (p)
      8'd0: return "c";   8'd1: return "h";   8'd2: return "u";   8'd3: return "n";
      8'd4: return "k";   8'd5: return "e";   8'd6: return "d";
      default: return 8'd0;
    endcase
  endfunction

endpackage

// ===== sv/hmbd_front.sv =====
module hmbd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  input  logic [7:0]        rx_byte,
  output logic              rx_stall,
  output logic              q_valid,
  output hmbd_pkg::item_t   q_item,
  input  logic              q_pop
);
  import hmbd_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign rx_stall = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = rx_valid && !rx_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: rx_byte, cls: classify(rx_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/hmbd_back.sv =====
module hmbd_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hmbd_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       kind,
  output logic [7:0]       body_byte,
  output logic             end_of_message,
  output logic [1:0]       error_code
);
  import hmbd_pkg::*;

  localparam int CB = COUNT_BITS;

  phase_t          phase, phase_next;
  logic            crp, crp_next;
  line_t           ln, ln_next;
  logic [CB-1:0]   rem, rem_next;
  logic [CB-1:0]   clv, clv_next;
  logic            len_present, len_present_next;
  logic            chunked_seen, chunked_seen_next;
  emit_t           em;
  logic            advance;

  function automatic logic [CB-1:0] acc_step(input logic [CB-1:0] a, input logic [3:0] d,
                                             input logic hex);
    logic [CB+3:0] w;
    w = hex ? ({4'b0, a} << 4) : (({4'b0, a} << 3) + ({4'b0, a} << 1));
    w = w + {{CB{1'b0}}, d};
    return (w[CB+3:CB] != 4'b0) ? '1 : w[CB-1:0];
  endfunction

  function automatic line_t fresh_line();
    line_t l;
    l = '0;
    l.kcl  = 1'b1;
    l.kte  = 1'b1;
    l.kchk = 1'b1;
    return l;
  endfunction

  function automatic void content_char(input item_t it, input phase_t ph, inout line_t l,
                                       inout logic [CB-1:0] acc);
    logic [7:0] c;
    logic       skip;
    c = it.data;
    skip = 1'b0;
    if (ph == PH_HEADER) begin
      if (!l.kcolon) begin
        if (c == CH_COLON) begin
          l.kcolon = 1'b1;
          if (l.pos == 8'd0) l.colon_bad = 1'b1;
          if (l.pos != CL_LEN) l.kcl = 1'b0;
          if (l.pos != TE_LEN) l.kte = 1'b0;
          l.vstart = 1'b1;
        end else begin
          if (!(l.pos < CL_LEN && c == cl_char(l.pos))) l.kcl = 1'b0;
          if (!(l.pos < TE_LEN && c == te_char(l.pos))) l.kte = 1'b0;
        end
      end else begin
        if (l.vstart) begin
          l.vstart = 1'b0;
          skip = (c == CH_SPACE);
        end
        if (!skip) begin
          if (!(l.vlen < CK_LEN && c == ck_char(l.vlen))) l.kchk = 1'b0;
          if (l.vlen != POS_MAX) l.vlen = l.vlen + 8'd1;
          if (l.np == NUM_IDLE) begin
            if (it.cls.is_blank) begin
              skip = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              l.neg = (c == CH_MINUS);
              l.np = NUM_DIGITS;
              skip = 1'b1;
            end else begin
              l.np = NUM_DIGITS;
            end
          end
          if (!skip && l.np == NUM_DIGITS) begin
            if (it.cls.is_dec) acc = acc_step(acc, it.cls.nib, 1'b0);
            else l.np = NUM_DONE;
          end
        end
      end
    end else if (ph == PH_CSIZE) begin
      if (l.np == NUM_IDLE || l.np == NUM_DIGITS) begin
        if (it.cls.is_hex) begin
          l.np = NUM_DIGITS;
          acc = acc_step(acc, it.cls.nib, 1'b1);
        end else if (l.np == NUM_IDLE) begin
          l.np = it.cls.is_sptab ? NUM_IDLE : NUM_BAD;
        end else begin
          l.np = NUM_DONE;
        end
      end
    end
    if (l.pos != POS_MAX) l.pos = l.pos + 8'd1;
  endfunction

  assign advance = q_valid && (!res_valid || !res_stall);
  assign q_pop   = advance;

  // Next state and the emitted result for the byte at the head of the queue.
  always_comb begin
    item_t cr_item;
    logic  empty;
    phase_next        = phase;
    crp_next          = crp;
    ln_next           = ln;
    rem_next          = rem;
    clv_next          = clv;
    len_present_next  = len_present;
    chunked_seen_next = chunked_seen;
    em                = '0;
    cr_item           = '{data: CH_CR, cls: classify(CH_CR)};
    empty             = (ln.pos == 8'd0);
    if (phase == PH_LENBODY || phase == PH_CDATA) begin
      em = '{fire: 1'b1, kind: KIND_BODY, data: q_item.data, eom: 1'b0, code: ERR_NO_COLON};
      if (rem[CB-1:1] == '0) begin
        if (phase == PH_LENBODY) begin
          em.eom = 1'b1;
          phase_next = PH_START;
        end else begin
          phase_next = PH_CSIZE;
        end
        ln_next  = fresh_line();
        rem_next = '0;
      end else begin
        rem_next = rem - 1'b1;
      end
    end else if (q_item.data == CH_LF && crp) begin
      crp_next = 1'b0;
      case (phase)
        PH_HEADER: begin
          if (!empty) begin
            if (!ln.kcolon || ln.colon_bad) begin
              em = '{fire: 1'b1, kind: KIND_ERROR, data: 8'd0, eom: 1'b0, code: ERR_NO_COLON};
            end else begin
              if (ln.kcl) begin
                len_present_next = (ln.vlen != 8'd0);
                clv_next = ln.neg ? '0 : rem;
              end
              if (ln.kte) chunked_seen_next = ln.kchk && (ln.vlen == CK_LEN);
              ln_next  = fresh_line();
              rem_next = '0;
            end
          end else if (len_present) begin
            ln_next = fresh_line();
            if (clv == '0) begin
              rem_next = '0;
              phase_next = PH_START;
              em = '{fire: 1'b1, kind: KIND_END, data: 8'd0, eom: 1'b1, code: ERR_NO_COLON};
            end else begin
              rem_next = clv;
              phase_next = PH_LENBODY;
            end
          end else if (chunked_seen) begin
            ln_next = fresh_line();
            rem_next = '0;
            phase_next = PH_CSIZE;
          end else begin
            em = '{fire: 1'b1, kind: KIND_ERROR, data: 8'd0, eom: 1'b0, code: ERR_NO_FRAME};
          end
        end
        PH_CSIZE: begin
          if (empty) begin
            ln_next = fresh_line();
            rem_next = '0;
          end else if (ln.np == NUM_IDLE || ln.np == NUM_BAD) begin
            em = '{fire: 1'b1, kind: KIND_ERROR, data: 8'd0, eom: 1'b0, code: ERR_BAD_SIZE};
          end else begin
            ln_next = fresh_line();
            phase_next = (rem == '0) ? PH_FOOTER : PH_CDATA;
          end
        end
        PH_FOOTER: begin
          ln_next = fresh_line();
          rem_next = '0;
          if (empty) begin
            phase_next = PH_START;
            em = '{fire: 1'b1, kind: KIND_END, data: 8'd0, eom: 1'b1, code: ERR_NO_COLON};
          end
        end
        default: begin
          ln_next = fresh_line();
          rem_next = '0;
          phase_next = PH_HEADER;
          len_present_next = 1'b0;
          chunked_seen_next = 1'b0;
          clv_next = '0;
        end
      endcase
      if (em.fire && em.kind == KIND_ERROR) begin
        phase_next = PH_START;
        crp_next = 1'b0;
        ln_next = fresh_line();
        rem_next = '0;
      end
    end else begin
      if (crp) content_char(cr_item, phase, ln_next, rem_next);
      if (q_item.data == CH_CR) begin
        crp_next = 1'b1;
      end else begin
        crp_next = 1'b0;
        content_char(q_item, phase, ln_next, rem_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      crp          <= 1'b0;
      ln           <= '0;
      rem          <= '0;
      clv          <= '0;
      len_present  <= 1'b0;
      chunked_seen <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        phase        <= phase_next;
        crp          <= crp_next;
        ln           <= ln_next;
        rem          <= rem_next;
        clv          <= clv_next;
        len_present  <= len_present_next;
        chunked_seen <= chunked_seen_next;
      end
      if (advance && em.fire) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && em.fire) begin
      kind           <= em.kind;
      body_byte      <= em.data;
      end_of_message <= em.eom;
      error_code     <= em.code;
    end
  end

endmodule

// ===== sv/http_message_body_deframer_core.sv =====
// HTTP/1.1 message body deframer.
// The rx channel takes one byte of the received stream per beat (rx_valid,
// rx_stall, rx_byte). The res channel gives zero or one result per byte:
// kind (body byte, message end or format error), body_byte,
// end_of_message and error_code, under res_valid and res_stall.
// An accepted byte enters the queue; its result is registered once the
// state machine takes it. Throughput is one byte per cycle unless res_stall
// holds a result: a two-beat queue feeds the combinational framing state
// machine, and the result register is loaded again in the cycle it is taken.
// The length counter is COUNT_BITS wide and saturates on long values.
// Synchronous reset empties the queue, drops any pending result and returns
// the parser to the start line of a new message.
// While res_stall is high with res_valid set, the result holds, the state machine pauses and
// the queue fills; rx_stall rises once both queue entries are occupied.
module http_message_body_deframer_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] kind,
  output logic [7:0] body_byte,
  output logic       end_of_message,
  output logic [1:0] error_code
);
  import hmbd_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  hmbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_stall (rx_stall),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hmbd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .body_byte      (body_byte),
    .end_of_message (end_of_message),
    .error_code     (error_code)
  );

endmodule

// ===== sv/hmbd_checker.sv =====
module hmbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] kind,
  input logic [7:0] body_byte,
  input logic       end_of_message,
  input logic [1:0] error_code
);
  import hmbd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(body_byte))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid && !rx_stall)
    else $error("result valid or input stalled after reset");

  a_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_ERROR |-> !end_of_message && error_code != 2'd3)
    else $error("bad error result");

  a_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> kind != 2'd3 &&
      (kind != KIND_END || (end_of_message && error_code == ERR_NO_COLON)))
    else $error("bad message end result");

  a_rx_hold: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_stall |=> rx_valid)
    else $error("stalled input beat withdrawn");

endmodule

bind http_message_body_deframer_core hmbd_checker u_hmbd_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_valid       (rx_valid),
  .rx_stall       (rx_stall),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .kind           (kind),
  .body_byte      (body_byte),
  .end_of_message (end_of_message),
  .error_code     (error_code)
);

// ===== tb/sv/tb_http_message_body_deframer_core.sv =====
module tb_http_message_body_deframer_core;
  import hmbd_pkg::*;

  localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
  localparam int IDLE_LIMIT = 4000;
  localparam int TARGET_BYTES = 1750;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       eom;
    logic [1:0] code;
  } deframe_res_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       res_valid;
  logic       res_stall;
  logic [1:0] kind;
  logic [7:0] body_byte;
  logic       end_of_message;
  logic [1:0] error_code;

  deframe_res_t pending_results[$];
  int mismatches;
  int bytes_sent;
  int idle_cycles;
  int stall_left;
  bit quiet;

  // Predictor state.
  phase_t          ph;
  bit              crp;
  int unsigned     pos;
  bit              kcl, kte, kcolon, kchk, cbad, vstart;
  int unsigned     vlen;
  int              np;
  bit              neg;
  longint unsigned clv, rem;
  bit              len_seen, chunk_seen;

  string cl_key = "Content-Length";
  string te_key = "Transfer-Encoding";
  string ck_val = "chunked";

  http_message_body_deframer_core u_top (
    .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall), .kind(kind), .body_byte(body_byte),
    .end_of_message(end_of_message), .error_code(error_code)
  );

  always #5 clk = ~clk;

  function automatic void new_line();
    pos = 0;
    kcl = 1;
    kte = 1;
    kchk = 1;
    kcolon = 0;
    cbad = 0;
    vstart = 0;
    vlen = 0;
    np = 0;
    neg = 0;
    rem = 0;
  endfunction

  function automatic deframe_res_t make_res(logic [1:0] k, logic [7:0] d, logic e,
                                            logic [1:0] c);
    deframe_res_t r;
    r.kind = k;
    r.data = d;
    r.eom = e;
    r.code = c;
    return r;
  endfunction

  function automatic deframe_res_t framing_error(logic [1:0] c);
    ph = PH_START;
    crp = 0;
    new_line();
    return make_res(KIND_ERROR, 8'd0, 1'b0, c);
  endfunction

  function automatic void header_char(logic [7:0] c);
    int unsigned p;
    longint unsigned d;
    p = pos;
    if (!kcolon) begin
      if (c == CH_COLON) begin
        kcolon = 1;
        if (p == 0) cbad = 1;
        if (p != 14) kcl = 0;
        if (p != 17) kte = 0;
        vstart = 1;
      end else begin
        if (!(p < 14 && c == cl_key[p])) kcl = 0;
        if (!(p < 17 && c == te_key[p])) kte = 0;
      end
      return;
    end
    if (vstart) begin
      vstart = 0;
      if (c == CH_SPACE) return;
    end
    if (!(vlen < 7 && c == ck_val[vlen])) kchk = 0;
    if (vlen < 255) vlen++;
    if (np == 0) begin
      if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        np = 1;
        return;
      end
      np = 1;
    end
    if (np == 1) begin
      if (c >= "0" && c <= "9") begin
        d = c - "0";
        if (rem > (COUNT_MAX - d) / 10) rem = COUNT_MAX;
        else rem = rem * 10 + d;
      end else begin
        np = 2;
      end
    end
  endfunction

  function automatic void size_char(logic [7:0] c);
    longint unsigned d;
    if (np >= 2) return;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    else begin
      if (np == 0) np = (c == CH_SPACE || c == 8'd9) ? 0 : 3;
      else np = 2;
      return;
    end
    np = 1;
    if (rem > (COUNT_MAX - d) / 16) rem = COUNT_MAX;
    else rem = rem * 16 + d;
  endfunction

  function automatic void content_char(logic [7:0] c);
    if (ph == PH_HEADER) header_char(c);
    else if (ph == PH_CSIZE) size_char(c);
    if (pos < 255) pos++;
  endfunction

  function automatic bit close_line(output deframe_res_t r);
    bit empty;
    longint unsigned v;
    empty = (pos == 0);
    case (ph)
      PH_HEADER: begin
        if (!empty) begin
          if (!kcolon || cbad) begin
            r = framing_error(ERR_NO_COLON);
            return 1;
          end
          if (kcl) begin
            len_seen = (vlen > 0);
            clv = neg ? 0 : rem;
          end
          if (kte) chunk_seen = kchk && vlen == 7;
          new_line();
          return 0;
        end
        if (len_seen) begin
          v = clv;
          new_line();
          if (v == 0) begin
            ph = PH_START;
            r = make_res(KIND_END, 8'd0, 1'b1, 2'd0);
            return 1;
          end
          rem = v;
          ph = PH_LENBODY;
          return 0;
        end
        if (chunk_seen) begin
          new_line();
          ph = PH_CSIZE;
          return 0;
        end
        r = framing_error(ERR_NO_FRAME);
        return 1;
      end
      PH_CSIZE: begin
        if (empty) begin
          new_line();
          return 0;
        end
        if (np == 0 || np == 3) begin
          r = framing_error(ERR_BAD_SIZE);
          return 1;
        end
        v = rem;
        new_line();
        if (v == 0) ph = PH_FOOTER;
        else begin
          rem = v;
          ph = PH_CDATA;
        end
        return 0;
      end
      PH_FOOTER: begin
        new_line();
        if (empty) begin
          ph = PH_START;
          r = make_res(KIND_END, 8'd0, 1'b1, 2'd0);
          return 1;
        end
        return 0;
      end
      default: begin
        new_line();
        ph = PH_HEADER;
        len_seen = 0;
        chunk_seen = 0;
        clv = 0;
        return 0;
      end
    endcase
  endfunction

  function automatic bit deframe_byte(logic [7:0] c, output deframe_res_t r);
    logic e;
    if (ph == PH_LENBODY || ph == PH_CDATA) begin
      e = 0;
      if (rem <= 1) begin
        if (ph == PH_LENBODY) begin
          e = 1;
          ph = PH_START;
        end else begin
          ph = PH_CSIZE;
        end
        new_line();
      end else begin
        rem--;
      end
      r = make_res(KIND_BODY, c, e, 2'd0);
      return 1;
    end
    if (c == CH_LF && crp) begin
      crp = 0;
      return close_line(r);
    end
    if (crp) content_char(CH_CR);
    if (c == CH_CR) crp = 1;
    else begin
      crp = 0;
      content_char(c);
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    deframe_res_t r;
    deframe_res_t x;
    bit any;
    any = 0;
    if (!rst && rx_valid && !rx_stall) begin
      any = 1;
      if (deframe_byte(rx_byte, r)) pending_results.push_back(r);
    end
    if (!rst && res_valid && !res_stall) begin
      any = 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d byte %0h eom %0d code %0d",
                   kind, body_byte, end_of_message, error_code);
      end else begin
        x = pending_results.pop_front();
        if (x.kind !== kind || x.data !== body_byte || x.eom !== end_of_message ||
            x.code !== error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind %0d byte %0h eom %0d code %0d, %s %0d %0h %0d %0d",
                     x.kind, x.data, x.eom, x.code, "got", kind, body_byte,
                     end_of_message, error_code);
        end
      end
    end
    if (any || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      res_stall = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      res_stall = ($urandom_range(0, 9) < 3);
      stall_left = $urandom_range(1, 10);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      rx_valid = 0;
      repeat (gap) @(negedge clk);
    end
    rx_valid = 1;
    rx_byte = b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_body(int n);
    for (int i = 0; i < n; i++) send_byte($urandom_range(0, 255));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    send_line("GET / HTTP/1.1");
    send_line("Content-Length: 2");
    send_line("");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("HTTP/1.1 200 OK");
    send_line("Transfer-Encoding: chunked");
    send_line("");
    send_line(" A");
    send_body(10);
    send_line("");
    send_line("0");
    send_line("X-Tail: t");
    send_line("");
    send_line("S");
    send_line("Content-Length: 0");
    send_line("");
    send_line("S");
    send_line("Content-Length: -4");
    send_line("");
    send_line("S");
    send_line("NoColonHere");
    send_line("S");
    send_line(":v");
    send_line("S");
    send_line("Host: x");
    send_line("");
    send_line("S");
    send_line("Transfer-Encoding: chunked");
    send_line("");
    send_line("-3");
    send_line("S");
    send_line("Content-Length: 99999999999999");
    send_line("Content-Length:\t+3x");
    send_line("");
    send_body(3);
    send_line("S");
    send_line("Transfer-Encoding: chunkedx");
    send_line("Content-Length: ");
    send_line("");
    send_text("S\r\r\nContent-Length: 1\n\r\n\r\nq");
  endtask

  task automatic send_size_line();
    case ($urandom_range(0, 9))
      0: send_line($sformatf(" %0H", $urandom_range(1, 15)));
      1: send_line($sformatf("%0hzz", $urandom_range(1, 15)));
      2: send_line("fffffffffff");
      default: send_line($sformatf("%0h", $urandom_range(1, 12)));
    endcase
  endtask

  task automatic send_random_message();
    int n;
    int pick;
    send_line("HTTP/1.1 200 OK");
    repeat ($urandom_range(0, 2)) send_line($sformatf("X-%0d: %0d", $urandom_range(0, 9),
                                                        $urandom_range(0, 99)));
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      n = $urandom_range(0, 12);
      send_line($sformatf("Content-Length: %0d", n));
      if ($urandom_range(0, 3) == 0) send_line("Transfer-Encoding: chunked");
      send_line("");
      send_body(n);
    end else if (pick < 18) begin
      send_line("Transfer-Encoding: chunked");
      send_line("");
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(1, 12);
        if ($urandom_range(0, 4) == 0) send_line("");
        send_line($sformatf("%0h", n));
        send_body(n);
        send_line("");
      end
      send_line("0");
      if ($urandom_range(0, 1)) send_line("Trailer: z");
      send_line("");
    end else begin
      // Broken framing: random line noise until the next message resynchronises.
      repeat ($urandom_range(1, 20)) send_byte($urandom_range(0, 255));
      if ($urandom_range(0, 1)) send_size_line();
      send_line("");
    end
  endtask

  task automatic test_random_traffic(int limit);
    while (bytes_sent < limit) send_random_message();
  endtask

  task automatic test_pressure_pause();
    wait_drained();
    send_random_message();
  endtask

  initial begin
    clk = 0;
    rst = 1;
    rx_valid = 0;
    rx_byte = 0;
    res_stall = 0;
    quiet = 0;
    mismatches = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    stall_left = 0;
    ph = PH_START;
    crp = 0;
    clv = 0;
    len_seen = 0;
    chunk_seen = 0;
    new_line();
    kcl = 0;
    kte = 0;
    kchk = 0;
    repeat (8) @(negedge clk);
    rst = 0;
    test_directed();
    test_random_traffic(TARGET_BYTES / 2);
    test_pressure_pause();
    test_random_traffic(TARGET_BYTES * 4 / 5);
    quiet = 1;
    test_random_traffic(TARGET_BYTES);
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
